// ----- hdl/assert_macros.svh -----
// Assertion macros used by the sensor frame builder RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication check on a clock, disabled while reset is low.
`define SFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Condition that must never hold, disabled while reset is low.
`define SFB_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define SFB_ASSERT(label, clk, rst_n, prop, msg)
`define SFB_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/sfb_pkg.sv -----
// Shared types, constants and the CRC byte step for the sensor frame builder.
// Used by every module under hdl; depends on nothing.
package sfb_pkg;

    localparam int FracBits   = 16;
    localparam int RawW       = 32;
    localparam int FactorW    = 10;
    localparam int ProdW      = RawW + FactorW;
    localparam int ScaledW    = 16;

    localparam logic [FactorW-1:0] FactorTenths = 10'd10;
    localparam logic [FactorW-1:0] FactorMilli  = 10'd1000;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'h1021;

    // Byte positions within one frame.
    localparam logic [3:0] PosStart   = 4'd0;
    localparam logic [3:0] PosLength  = 4'd1;
    localparam logic [3:0] PosCommand = 4'd2;
    localparam logic [3:0] PosId      = 4'd3;
    localparam logic [3:0] PosCurHi   = 4'd4;
    localparam logic [3:0] PosCurLo   = 4'd5;
    localparam logic [3:0] PosPredHi  = 4'd6;
    localparam logic [3:0] PosPredLo  = 4'd7;
    localparam logic [3:0] PosCrcHi   = 4'd8;
    localparam logic [3:0] PosCrcLo   = 4'd9;
    localparam logic [3:0] PosEnd     = 4'd10;

    // Configuration register indexes.
    localparam logic [2:0] RegStart   = 3'd0;
    localparam logic [2:0] RegLength  = 3'd1;
    localparam logic [2:0] RegCommand = 3'd2;
    localparam logic [2:0] RegEnd     = 3'd3;
    localparam logic [2:0] RegTenthsA = 3'd4;
    localparam logic [2:0] RegTenthsB = 3'd5;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] length_byte;
        logic [7:0] command_byte;
        logic [7:0] end_byte;
    } frame_cfg_t;

    typedef struct packed {
        logic [7:0]         sensor_id;
        logic [ScaledW-1:0] current;
        logic [ScaledW-1:0] predicted;
    } frame_fields_t;

    // One CRC-16/CCITT-FALSE byte update, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (acc[15])
            begin
                acc = {acc[14:0], 1'b0} ^ CrcPoly;
            end
            else
            begin
                acc = {acc[14:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

// ----- hdl/sfb_scale_lane.sv -----
// One scaling lane: registered reading-times-factor product, then the
// fraction drop and 16-bit saturation. Depends on sfb_pkg.
module sfb_scale_lane
(
    input  logic                           clk,
    input  logic                           load,
    input  logic [sfb_pkg::RawW-1:0]       raw,
    input  logic [sfb_pkg::FactorW-1:0]    factor,
    output logic [sfb_pkg::ScaledW-1:0]    scaled
);

    logic [sfb_pkg::ProdW-1:0] prod_reg;
    logic [sfb_pkg::ProdW-1:0] prod_next;

    assign prod_next = {{sfb_pkg::FactorW{1'b0}}, raw} *
                       {{sfb_pkg::RawW{1'b0}}, factor};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Saturate when any bit above the 16-bit whole part is set.
    always_comb
    begin
        if (|prod_reg[sfb_pkg::ProdW-1:sfb_pkg::FracBits+sfb_pkg::ScaledW])
        begin
            scaled = {sfb_pkg::ScaledW{1'b1}};
        end
        else
        begin
            scaled = prod_reg[sfb_pkg::FracBits+sfb_pkg::ScaledW-1:sfb_pkg::FracBits];
        end
    end

endmodule

// ----- hdl/sfb_frame_ser.sv -----
// Merging stage: takes the lane results, emits the 11-byte frame one byte
// per transfer and folds bytes 1..7 into the CRC. Depends on sfb_pkg.
`include "assert_macros.svh"

module sfb_frame_ser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sfb_pkg::frame_fields_t in_fields,
    input  sfb_pkg::frame_cfg_t    cfg,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    sfb_pkg::frame_fields_t fields_reg;
    logic                   active_reg;
    logic [3:0]             pos_reg;
    logic [15:0]            crc_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;
    logic                   out_last_reg;

    logic                   advance;
    logic                   finishing;
    logic                   load;
    logic [7:0]             cur_byte;
    logic                   in_crc;

    assign advance   = !out_valid_reg || m_tready;
    assign finishing = advance && active_reg && (pos_reg == sfb_pkg::PosEnd);
    assign load      = in_valid && (!active_reg || finishing);
    assign in_ready  = !active_reg || finishing;
    assign in_crc    = (pos_reg >= sfb_pkg::PosLength) && (pos_reg <= sfb_pkg::PosPredLo);

    always_comb
    begin
        case (pos_reg)
            sfb_pkg::PosStart:   cur_byte = cfg.start_byte;
            sfb_pkg::PosLength:  cur_byte = cfg.length_byte;
            sfb_pkg::PosCommand: cur_byte = cfg.command_byte;
            sfb_pkg::PosId:      cur_byte = fields_reg.sensor_id;
            sfb_pkg::PosCurHi:   cur_byte = fields_reg.current[15:8];
            sfb_pkg::PosCurLo:   cur_byte = fields_reg.current[7:0];
            sfb_pkg::PosPredHi:  cur_byte = fields_reg.predicted[15:8];
            sfb_pkg::PosPredLo:  cur_byte = fields_reg.predicted[7:0];
            sfb_pkg::PosCrcHi:   cur_byte = crc_reg[15:8];
            sfb_pkg::PosCrcLo:   cur_byte = crc_reg[7:0];
            sfb_pkg::PosEnd:     cur_byte = cfg.end_byte;
            default:             cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pos_reg       <= sfb_pkg::PosStart;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= active_reg;
            end
            if (load)
            begin
                active_reg <= 1'b1;
                pos_reg    <= sfb_pkg::PosStart;
            end
            else if (finishing)
            begin
                active_reg <= 1'b0;
                pos_reg    <= sfb_pkg::PosStart;
            end
            else if (advance && active_reg)
            begin
                pos_reg <= pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fields_reg <= in_fields;
            crc_reg    <= sfb_pkg::CrcInit;
        end
        else if (advance && active_reg && in_crc)
        begin
            crc_reg <= sfb_pkg::crc_step(crc_reg, cur_byte);
        end
        if (advance && active_reg)
        begin
            out_data_reg <= cur_byte;
            out_last_reg <= (pos_reg == sfb_pkg::PosEnd);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `SFB_ASSERT(a_pos_range, clk, rst_n, active_reg |-> (pos_reg <= sfb_pkg::PosEnd), "frame position out of range")
    `SFB_ASSERT(a_crc_seed, clk, rst_n, (active_reg && pos_reg == sfb_pkg::PosStart) |-> (crc_reg == sfb_pkg::CrcInit), "CRC not seeded at frame start")
    `SFB_ASSERT(a_last_ends, clk, rst_n, (out_valid_reg && out_last_reg) |-> (!active_reg || pos_reg == sfb_pkg::PosStart), "last byte shown while frame still mid-way")
    `SFB_ASSERT(a_pos_step, clk, rst_n, (advance && active_reg && pos_reg != sfb_pkg::PosEnd) |=> (active_reg && pos_reg == $past(pos_reg) + 4'd1), "frame position skipped")

endmodule

// ----- hdl/sensor_frame_builder_crc16.sv -----
// Top level of the sensor frame builder: configuration registers, two
// scaling lanes and the frame serializer. Depends on sfb_pkg,
// sfb_scale_lane and sfb_frame_ser.
//
//  Channel   Direction  Payload                                   Handshake
//  s_*       in         tdata[7:0] sensor_id, [39:8] current,     tvalid/tready
//                       [71:40] predicted (unsigned Q16.16)
//  m_*       out        tdata[7:0] frame byte, tlast last byte    tvalid/tready
//  cfg_*     in         cfg_index register, cfg_wdata value       cfg_we only
//
// The input transfer registers both lane products; the serializer loads
// them once it is ready, then emits 11 bytes, one per cycle unless m_tready
// stalls, with each byte registered out. The serializer's 11-byte walk sets
// the sustained input rate; the lane slot can hold the next input meanwhile.
// The next frame loads in the cycle its predecessor's end byte is produced,
// so frames stream with no gap. A stall on m_tready holds the output byte
// and, through the lane slot, backs up to s_tready.
// rst_n clears control state and loads the default frame bytes and ids.
module sensor_frame_builder_crc16
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [7:0] sensor_id, [39:8] current_value, [71:40] predicted_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] frame_byte
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    // Configuration registers.
    sfb_pkg::frame_cfg_t cfg_reg;
    logic [7:0]          tenths_a_reg;
    logic [7:0]          tenths_b_reg;

    // Lane slot: one item between the input transfer and the serializer.
    logic                lane_valid_reg;
    logic [7:0]          lane_id_reg;

    logic                s_fire;
    logic                ser_ready;
    logic                use_tenths;
    logic [sfb_pkg::FactorW-1:0] factor;
    logic [sfb_pkg::ScaledW-1:0] cur_scaled;
    logic [sfb_pkg::ScaledW-1:0] pred_scaled;
    sfb_pkg::frame_fields_t      lane_fields;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte   <= 8'hAA;
            cfg_reg.length_byte  <= 8'h08;
            cfg_reg.command_byte <= 8'h01;
            cfg_reg.end_byte     <= 8'h55;
            tenths_a_reg         <= 8'h00;
            tenths_b_reg         <= 8'h02;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sfb_pkg::RegStart:   cfg_reg.start_byte   <= cfg_wdata;
                sfb_pkg::RegLength:  cfg_reg.length_byte  <= cfg_wdata;
                sfb_pkg::RegCommand: cfg_reg.command_byte <= cfg_wdata;
                sfb_pkg::RegEnd:     cfg_reg.end_byte     <= cfg_wdata;
                sfb_pkg::RegTenthsA: tenths_a_reg         <= cfg_wdata;
                sfb_pkg::RegTenthsB: tenths_b_reg         <= cfg_wdata;
                default:             ;  // drop writes past the register list
            endcase
        end
    end

    // Accept a new reading whenever the lane slot is empty or drains now.
    assign s_tready   = !lane_valid_reg || ser_ready;
    assign s_fire     = s_tvalid && s_tready;

    // Pick the scale once per item from the id.
    assign use_tenths = (s_tdata[7:0] == tenths_a_reg) || (s_tdata[7:0] == tenths_b_reg);
    assign factor     = use_tenths ? sfb_pkg::FactorTenths : sfb_pkg::FactorMilli;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            lane_valid_reg <= 1'b1;
        end
        else if (ser_ready)
        begin
            lane_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            lane_id_reg <= s_tdata[7:0];
        end
    end

    sfb_scale_lane u_lane_cur
    (
        .clk    (clk),
        .load   (s_fire),
        .raw    (s_tdata[39:8]),
        .factor (factor),
        .scaled (cur_scaled)
    );

    sfb_scale_lane u_lane_pred
    (
        .clk    (clk),
        .load   (s_fire),
        .raw    (s_tdata[71:40]),
        .factor (factor),
        .scaled (pred_scaled)
    );

    // Merge both lanes with the id into one frame item.
    assign lane_fields.sensor_id = lane_id_reg;
    assign lane_fields.current   = cur_scaled;
    assign lane_fields.predicted = pred_scaled;

    sfb_frame_ser u_ser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_valid_reg),
        .in_ready  (ser_ready),
        .in_fields (lane_fields),
        .cfg       (cfg_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
